FILE: src/nadir_smoothstep_weight_assert.svh
// Assertion macros shared by the weighting block.
`ifndef NADIR_SMOOTHSTEP_WEIGHT_ASSERT_SVH
`define NADIR_SMOOTHSTEP_WEIGHT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define NSW_ASSERT_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("nsw assertion failed");

// Next-cycle implication, disabled during reset.
`define NSW_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("nsw assertion failed");

`endif

FILE: src/nsw_pkg.sv
`default_nettype none

package nsw_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Factor register widths
  localparam int INNER_W = 9;
  localparam int OUTER_W = 10;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER  = 2'd2;

  // Reset values
  localparam logic               ENABLE_RST = 1'b1;
  localparam logic [INNER_W-1:0] INNER_RST  = 9'd77;
  localparam logic [OUTER_W-1:0] OUTER_RST  = 10'd256;

  // Write clamp limits
  localparam logic [CFG_DATA_W-1:0] INNER_MAX = 32'd384;
  localparam logic [CFG_DATA_W-1:0] OUTER_MIN = 32'd26;
  localparam logic [CFG_DATA_W-1:0] OUTER_MAX = 32'd640;

  // Side-band outcome travelling alongside the divider data
  typedef struct packed {
    logic zero;   // weight forced to 0
    logic one;    // weight forced to 1.0
  } nsw_tag_t;

endpackage

`default_nettype wire

FILE: src/nsw_sample_if.sv
`default_nettype none

interface nsw_sample_if #(
  parameter int DIST_BITS = 24
) ();
  logic                        valid;
  logic                        ready;
  logic signed [DIST_BITS-1:0] ground_offset;
  logic signed [DIST_BITS-1:0] depth;

  modport source (output valid, output ground_offset, output depth, input ready);
  modport sink   (input valid, input ground_offset, input depth, output ready);
endinterface

`default_nettype wire

FILE: src/nsw_result_if.sv
`default_nettype none

interface nsw_result_if #(
  parameter int WEIGHT_FRAC_BITS = 16
) ();
  logic                      valid;
  logic                      ready;
  logic [WEIGHT_FRAC_BITS:0] weight;

  modport source (output valid, output weight, input ready);
  modport sink   (input valid, input weight, output ready);
endinterface

`default_nettype wire

FILE: src/nsw_cfg_if.sv
`default_nettype none

interface nsw_cfg_if ();
  import nsw_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/nadir_smoothstep_weight.sv
// Channel  | Dir | Payload                                  | Handshake
// sample   | in  | ground_offset, depth (DIST_BITS, signed) | valid / ready
// result   | out | weight (WEIGHT_FRAC_BITS+1, unsigned)     | valid / ready
// cfg      | in  | index (2), data (32)                     | valid / ready (always ready)
//
// One sample accepted per cycle while result is not stalled; the divider resolves
// one quotient bit per pipeline stage.
// Synchronous reset clears all valid bits and loads the register defaults.
// A stall on result freezes the whole pipeline; sample.ready drops in the same cycle.
`default_nettype none

module nadir_smoothstep_weight #(
  parameter int DIST_BITS        = 24,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  nsw_sample_if.sink   sample,
  nsw_result_if.source result,
  nsw_cfg_if.sink      cfg
);
  import nsw_pkg::*;

  localparam int D  = DIST_BITS;
  localparam int F  = WEIGHT_FRAC_BITS;
  localparam int PW = D + 11;
  localparam logic [F:0]   WONE   = {1'b1, {F{1'b0}}};
  localparam logic [F+1:0] WTHREE = {2'b11, {F{1'b0}}};

  // Configuration registers
  logic               enable;
  logic [INNER_W-1:0] inner_factor;
  logic [OUTER_W-1:0] outer_factor;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable       <= ENABLE_RST;
      inner_factor <= INNER_RST;
      outer_factor <= OUTER_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ENABLE: enable <= cfg.data[0];
        REG_INNER:  inner_factor <= (cfg.data > INNER_MAX) ? INNER_MAX[INNER_W-1:0]
                                                           : cfg.data[INNER_W-1:0];
        REG_OUTER: begin
          if (cfg.data < OUTER_MIN) begin
            outer_factor <= OUTER_MIN[OUTER_W-1:0];
          end else if (cfg.data > OUTER_MAX) begin
            outer_factor <= OUTER_MAX[OUTER_W-1:0];
          end else begin
            outer_factor <= cfg.data[OUTER_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Pipeline advance: output free or being taken
  logic adv;
  logic ov;
  assign adv          = !ov || result.ready;
  assign sample.ready = adv;

  // Stage 1: capture sample
  logic                v1;
  logic signed [D-1:0] off1;
  logic signed [D-1:0] dep1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      off1 <= sample.ground_offset;
      dep1 <= sample.depth;
    end
  end

  // Stage 2: bounds in Q.8 metres
  logic signed [10:0]   of_s;
  logic signed [10:0]   if_s;
  logic signed [PW-1:0] outer_p;
  logic signed [PW-1:0] inner_p;
  logic                 v2;
  logic                 dz2;
  logic signed [PW-1:0] outer2;
  logic signed [PW-1:0] inner2;
  logic signed [PW-1:0] off2;

  assign of_s    = signed'({1'b0, outer_factor});
  assign if_s    = signed'({2'b00, inner_factor});
  assign outer_p = PW'(of_s) * PW'(dep1);
  assign inner_p = PW'(if_s) * PW'(dep1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dz2    <= !enable || dep1[D-1] || (dep1 == '0);
      outer2 <= outer_p;
      inner2 <= inner_p;
      off2   <= {{3{off1[D-1]}}, off1, 8'b0};
    end
  end

  // Stage 3: special cases, dividend and divisor
  logic signed [PW-1:0] inner_eff;
  nsw_tag_t             tag_next;
  logic                 v3;
  logic [PW-1:0]        num3;
  logic [PW-1:0]        den3;
  nsw_tag_t             tag3;

  always_comb begin
    inner_eff     = (inner2 >= outer2) ? '0 : inner2;
    tag_next.zero = dz2 || (outer2 <= 0) || (off2 >= outer2);
    tag_next.one  = !tag_next.zero && (off2 <= inner_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num3 <= PW'(outer2 - off2);
      den3 <= PW'(outer2 - inner_eff);
      tag3 <= tag_next;
    end
  end

  // Fraction u, one bit per stage
  logic         vd;
  logic [F-1:0] ud;
  nsw_tag_t     tagd;

  nsw_div #(
    .PW (PW),
    .F  (F)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (v3),
    .in_num    (num3),
    .in_den    (den3),
    .in_tag    (tag3),
    .out_valid (vd),
    .out_q     (ud),
    .out_tag   (tagd)
  );

  // Square stage: s = u*u >> F
  logic [2*F-1:0] sq;
  logic           vs;
  logic [F-1:0]   s4;
  logic [F-1:0]   u4;
  nsw_tag_t       tag4;

  assign sq = (2*F)'(ud) * (2*F)'(ud);

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= 1'b0;
    end else if (adv) begin
      vs <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4   <= sq[2*F-1:F];
      u4   <= ud;
      tag4 <= tagd;
    end
  end

  // Output stage: w = s*(3 - 2u) >> F, then special cases
  logic [F+1:0]   tri_term;
  logic [2*F+1:0] wp;
  logic [F:0]     w_next;
  logic [F:0]     weight_r;

  always_comb begin
    tri_term = WTHREE - {1'b0, u4, 1'b0};
    wp       = (2*F+2)'(s4) * (2*F+2)'(tri_term);
    if (tag4.zero) begin
      w_next = '0;
    end else if (tag4.one) begin
      w_next = WONE;
    end else begin
      w_next = wp[2*F:F];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (adv) begin
      ov <= vs;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      weight_r <= w_next;
    end
  end

  assign result.valid  = ov;
  assign result.weight = weight_r;

`include "nadir_smoothstep_weight_assert.svh"

  // The weight never exceeds 1.0
  `NSW_ASSERT_IMPLY(a_weight_range, clk, rst, result.valid, result.weight <= WONE)
  // Forced-zero and forced-one outcomes exclude each other
  `NSW_ASSERT_IMPLY(a_tag_excl, clk, rst, v3, !(tag3.zero && tag3.one))
  // A disabled or non-positive-depth item always ends up forced to zero
  `NSW_ASSERT_NEXT(a_dz_zero, clk, rst, adv && v2 && dz2, v3 && tag3.zero)

endmodule

`default_nettype wire

FILE: src/nsw_div.sv
`default_nettype none

// Pipelined restoring divider: floor(num * 2^F / den) for num < den,
// one quotient bit per register stage.
module nsw_div #(
  parameter int PW = 35,
  parameter int F  = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              adv,
  input  wire logic              in_valid,
  input  wire logic [PW-1:0]     in_num,
  input  wire logic [PW-1:0]     in_den,
  input  wire nsw_pkg::nsw_tag_t in_tag,
  output logic                   out_valid,
  output logic [F-1:0]           out_q,
  output nsw_pkg::nsw_tag_t      out_tag
);
  import nsw_pkg::*;

  // Registered stages 1..F; stage 0 is the incoming item
  logic          v   [1:F];
  logic [PW-1:0] rem [1:F];
  logic [PW-1:0] den [1:F];
  logic [F-1:0]  q   [1:F];
  nsw_tag_t      tag [1:F];

  for (genvar i = 0; i < F; i++) begin : g_step
    logic          v_in;
    logic [PW-1:0] rem_in;
    logic [PW-1:0] den_in;
    logic [F-1:0]  q_in;
    nsw_tag_t      tag_in;
    logic [PW:0]   shifted;
    logic          ge;

    // Step input: the incoming item or the previous stage
    if (i == 0) begin : g_head
      assign v_in   = in_valid;
      assign rem_in = in_num;
      assign den_in = in_den;
      assign q_in   = '0;
      assign tag_in = in_tag;
    end else begin : g_link
      assign v_in   = v[i];
      assign rem_in = rem[i];
      assign den_in = den[i];
      assign q_in   = q[i];
      assign tag_in = tag[i];
    end

    // Shift, trial subtract, keep or restore
    assign shifted = {rem_in, 1'b0};
    assign ge      = shifted >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (adv) begin
        v[i+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[i+1] <= ge ? PW'(shifted - {1'b0, den_in}) : shifted[PW-1:0];
        den[i+1] <= den_in;
        q[i+1]   <= {q_in[F-2:0], ge};
        tag[i+1] <= tag_in;
      end
    end
  end

  assign out_valid = v[F];
  assign out_q     = q[F];
  assign out_tag   = tag[F];

`include "nadir_smoothstep_weight_assert.svh"

  // A real division enters with a proper fraction
  `NSW_ASSERT_IMPLY(a_div_entry, clk, rst, in_valid && !in_tag.zero && !in_tag.one, in_num < in_den)
  // The remainder stays below the divisor through the last step
  `NSW_ASSERT_IMPLY(a_div_exit, clk, rst, v[F] && !tag[F].zero && !tag[F].one, rem[F] < den[F])
  // A stall freezes the last stage
  `NSW_ASSERT_NEXT(a_div_hold, clk, rst, !adv, $stable(v[F]) && $stable(q[F]))

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import nsw_pkg::*;

  localparam int DIST_BITS   = 24;
  localparam int WFRAC       = 16;
  localparam int LATENCY     = WFRAC + 5;
  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 250;
  localparam int PRINT_CAP   = 100;

  // Index with no register behind it; writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef logic signed [DIST_BITS-1:0] dist_t;
  typedef logic [WFRAC:0]              weight_t;

  localparam weight_t W_ZERO  = '0;
  localparam weight_t W_ONE   = weight_t'(1) << WFRAC;
  localparam dist_t   D_MAX   = 24'sh7FFFFF;
  localparam dist_t   D_MIN   = 24'sh800000;
  localparam longint  DIST_HI = 64'sd8388607;
  localparam longint  DIST_LO = -64'sd8388608;

  typedef struct {
    dist_t   off;
    dist_t   dep;
    bit      known;
    weight_t w;
  } sample_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  nsw_sample_if #(.DIST_BITS(DIST_BITS)) sample ();
  nsw_result_if #(.WEIGHT_FRAC_BITS(WFRAC)) result ();
  nsw_cfg_if cfg ();

  nadir_smoothstep_weight #(
    .DIST_BITS       (DIST_BITS),
    .WEIGHT_FRAC_BITS(WFRAC)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .sample(sample),
    .result(result),
    .cfg   (cfg)
  );

  // Register copies used for prediction
  logic               en_copy    = ENABLE_RST;
  logic [INNER_W-1:0] inner_copy = INNER_RST;
  logic [OUTER_W-1:0] outer_copy = OUTER_RST;

  weight_t expected_weights [$];
  int      err_count     = 0;
  int      sent_count    = 0;
  int      checked_count = 0;
  int      setting_count = 0;
  int      ramp_count    = 0;
  int      idle_cycles   = 0;
  bit      quiet         = 1'b0;
  bit      hold_req      = 1'b0;

  // Directed samples at reset register values; weights typed in where obvious
  sample_row_t directed_rows [20] = '{
    '{24'sd0,      24'sd0,         1'b1, W_ZERO},  // zero depth
    '{24'sd0,      -24'sd1,        1'b1, W_ZERO},  // negative depth
    '{24'sd0,      D_MIN,          1'b1, W_ZERO},
    '{D_MIN,       D_MAX,          1'b1, W_ONE},
    '{D_MAX,       D_MAX,          1'b1, W_ZERO},  // exactly on the outer bound
    '{24'sd0,      24'sd256,       1'b1, W_ONE},
    '{24'sd256,    24'sd256,       1'b1, W_ZERO},
    '{24'sd255,    24'sd256,       1'b0, W_ZERO},
    '{24'sd77,     24'sd256,       1'b1, W_ONE},   // exactly on the inner bound
    '{24'sd78,     24'sd256,       1'b0, W_ZERO},
    '{24'sd166,    24'sd256,       1'b0, W_ZERO},
    '{24'sd0,      24'sd1,         1'b1, W_ONE},
    '{24'sd1,      24'sd1,         1'b1, W_ZERO},
    '{-24'sd1,     24'sd1,         1'b1, W_ONE},
    '{D_MIN,       24'sd1,         1'b1, W_ONE},
    '{D_MAX,       D_MIN,          1'b1, W_ZERO},
    '{24'sh555555, 24'sh2AAAAA,    1'b1, W_ZERO},
    '{24'sh2AAAAA, 24'sh555555,    1'b0, W_ZERO},
    '{D_MAX,       24'sd1,         1'b1, W_ZERO},
    '{-24'sd256,   D_MAX,          1'b1, W_ONE}
  };

  // Smoothstep weight from the current register copies
  function automatic weight_t weight_of(dist_t off, dist_t dep);
    longint          outer_b, inner_b, off16;
    longint unsigned rem, den, u, sq, w;
    if (!en_copy || dep <= 0) return W_ZERO;
    outer_b = longint'(outer_copy) * longint'(dep);
    off16   = longint'(off) * 256;
    if (outer_b <= 0 || off16 >= outer_b) return W_ZERO;
    inner_b = longint'(inner_copy) * longint'(dep);
    if (inner_b >= outer_b) inner_b = 0;
    if (off16 <= inner_b) return W_ONE;
    // ramp position, one quotient bit per step
    rem = outer_b - off16;
    den = outer_b - inner_b;
    u   = 0;
    for (int i = 0; i < WFRAC; i++) begin
      rem = rem << 1;
      u   = u << 1;
      if (rem >= den) begin
        rem = rem - den;
        u   = u | 1;
      end
    end
    sq = (u * u) >> WFRAC;
    w  = (sq * ((longint'(3) << WFRAC) - 2 * u)) >> WFRAC;
    return weight_t'(w);
  endfunction

  function automatic dist_t clip_dist(longint v);
    if (v > DIST_HI) return D_MAX;
    if (v < DIST_LO) return D_MIN;
    return dist_t'(v);
  endfunction

  // Random sample, mostly placed around the ramp of the current setting
  function automatic void pick_sample(output dist_t off, output dist_t dep);
    longint      lo, hi, d;
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 3) == 0) d = $urandom_range(1, 8388607);
    else                           d = $urandom_range(1, 4096);
    if (kind >= 75 && kind < 85) d = 256 * longint'($urandom_range(1, 8000));
    lo = (longint'(inner_copy) * d) >>> 8;
    hi = (longint'(outer_copy) * d) >>> 8;
    if (lo >= hi) lo = 0;
    dep = clip_dist(d);
    if (kind < 60) begin
      off = clip_dist(lo - 2 + longint'($urandom % (hi - lo + 5)));
    end else if (kind < 75) begin
      off = dist_t'($urandom);
      dep = dist_t'($urandom);
    end else if (kind < 85) begin
      // on or next to a bound
      off = clip_dist(($urandom_range(0, 1) ? hi : lo) + $urandom_range(0, 2) - 1);
    end else if (kind < 93) begin
      off = dist_t'($urandom);
      dep = clip_dist(-longint'($urandom_range(0, 8388608)));
    end else begin
      off = clip_dist(-longint'($urandom_range(1, 8388608)));
    end
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < PRINT_CAP) $display("[%0t] MISMATCH %s", $realtime, msg);
    err_count++;
  endtask

  // Offer one sample after a random gap; valid stays high afterwards
  task automatic send_sample(input dist_t off, input dist_t dep, input bit known,
                             input weight_t w_known);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      sample.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample.valid         <= 1'b1;
    sample.ground_offset <= off;
    sample.depth         <= dep;
    do @(posedge clk); while (!sample.ready);
    expected_weights.push_back(known ? w_known : weight_of(off, dep));
    sent_count++;
  endtask

  // Stop offering and wait for every outstanding weight
  task automatic drain();
    sample.valid <= 1'b0;
    while (expected_weights.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_ENABLE: en_copy = data[0];
      REG_INNER:  inner_copy = (data > INNER_MAX) ? INNER_MAX[INNER_W-1:0] : data[INNER_W-1:0];
      REG_OUTER: begin
        if (data < OUTER_MIN)      outer_copy = OUTER_MIN[OUTER_W-1:0];
        else if (data > OUTER_MAX) outer_copy = OUTER_MAX[OUTER_W-1:0];
        else                       outer_copy = data[OUTER_W-1:0];
      end
      default: ;
    endcase
  endtask

  // New register setting, only with the pipeline empty
  task automatic apply_setting(input logic [CFG_DATA_W-1:0] en_data,
                               input logic [CFG_DATA_W-1:0] inner_data,
                               input logic [CFG_DATA_W-1:0] outer_data,
                               input bit spare);
    drain();
    write_reg(REG_ENABLE, en_data);
    write_reg(REG_INNER, inner_data);
    write_reg(REG_OUTER, outer_data);
    if (spare) write_reg(REG_SPARE, $urandom);
    cfg.valid <= 1'b0;
    setting_count++;
  endtask

  // Weight receiver with random back-pressure and one long hold-off
  initial begin : weight_sink
    int      gap;
    weight_t want;
    result.ready <= 1'b0;
    wait (!rst);
    forever begin
      if (hold_req) begin
        result.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        result.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result.ready <= 1'b1;
      do @(posedge clk); while (!result.valid);
      if (expected_weights.size() == 0) begin
        report_mismatch($sformatf("weight %0d with nothing outstanding", result.weight));
      end else begin
        want = expected_weights.pop_front();
        checked_count++;
        if (want != W_ZERO && want != W_ONE) ramp_count++;
        if (result.weight !== want)
          report_mismatch($sformatf("weight got %0d, expected %0d", result.weight, want));
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (sample.valid && sample.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus
  initial begin : stimulus
    dist_t off, dep;
    sample.valid         <= 1'b0;
    sample.ground_offset <= '0;
    sample.depth         <= '0;
    cfg.valid            <= 1'b0;
    cfg.index            <= REG_ENABLE;
    cfg.data             <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_sample(directed_rows[i].off, directed_rows[i].dep, directed_rows[i].known,
                  directed_rows[i].w);

    for (int phase = 0; phase < N_PHASES; phase++) begin
      case (phase)
        0: apply_setting(32'd1, 32'd0, 32'd26, 1'b0);
        1: apply_setting(32'd1, 32'd384, 32'd640, 1'b0);
        2: apply_setting(32'd2, 32'd1000, 32'd0, 1'b1);            // disabled, clamped
        3: apply_setting(32'd3, 32'd384, 32'd26, 1'b0);            // inner above outer
        4: apply_setting(32'd1, 32'd200, 32'hFFFF_FFFF, 1'b0);
        5: apply_setting(32'd1, $urandom_range(0, 511), $urandom_range(0, 1023), 1'b1);
        6: apply_setting($urandom, $urandom, $urandom_range(26, 640), 1'b0);
        default: apply_setting(32'd1, 32'd385, 32'd25, 1'b0);
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        quiet = (phase == 1 && n < 100) || (phase == 4 && n >= 100 && n < 200);
        if (phase == 4 && n == 100) hold_req = 1'b1;
        if (phase == 6 && n == 125) drain();
        pick_sample(off, dep);
        send_sample(off, dep, 1'b0, W_ZERO);
      end
    end
    quiet = 1'b0;

    // Wind down
    drain();
    repeat (2 * LATENCY) @(posedge clk);
    if (expected_weights.size() != 0)
      report_mismatch($sformatf("%0d weights never arrived", expected_weights.size()));
    $display("covered %0d samples under %0d register settings, %0d weights checked",
             sent_count, setting_count + 1, checked_count);
    $display("%0d weights on the ramp; one long output stall and one mid-run drain",
             ramp_count);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: nadir_smoothstep_weight.f
+incdir+src
src/nsw_pkg.sv
src/nsw_sample_if.sv
src/nsw_result_if.sv
src/nsw_cfg_if.sv
src/nsw_div.sv
src/nadir_smoothstep_weight.sv
dv/testbench.sv
